/* sv/flk_pkg.sv */
// Shared types and constants for the IPv4 flow key extractor.
`timescale 1ns / 1ps
package flk_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
  } out_item_t;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_BAD_VER   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // frame layout
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd34;
  localparam logic [15:0] ETHERTYPE_IP4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  TCP_HDR_LEN   = 8'd20;
  localparam logic [7:0]  UDP_HDR_LEN   = 8'd8;

  localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFF_VER_IHL  = 16'd14;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_SRC_0    = 16'd26;
  localparam logic [15:0] OFF_SRC_1    = 16'd27;
  localparam logic [15:0] OFF_SRC_2    = 16'd28;
  localparam logic [15:0] OFF_SRC_3    = 16'd29;
  localparam logic [15:0] OFF_DST_0    = 16'd30;
  localparam logic [15:0] OFF_DST_1    = 16'd31;
  localparam logic [15:0] OFF_DST_2    = 16'd32;
  localparam logic [15:0] OFF_DST_3    = 16'd33;

  // result queue
  localparam int Q_PTR_W = 2;
  localparam int Q_DEPTH = 1 << Q_PTR_W;
  localparam int Q_LVL_W = Q_PTR_W + 1;
  localparam logic [Q_LVL_W-1:0] Q_FULL_LVL = Q_LVL_W'(Q_DEPTH);
  localparam logic [Q_PTR_W-1:0] Q_PTR_ONE  = Q_PTR_W'(1);
  localparam logic [Q_LVL_W-1:0] Q_LVL_ONE  = Q_LVL_W'(1);

endpackage

/* sv/flk_front.sv */
// Front end: byte counting, header field capture and frame classification.
`timescale 1ns / 1ps
module flk_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  flk_pkg::in_item_t                 in_data,
  input  logic [flk_pkg::Q_LVL_W-1:0]       q_level,
  output logic                              q_push,
  output flk_pkg::out_item_t                q_wdata
);

  logic [15:0] count_r, count_nxt, len_r;
  logic        pend_r;
  logic        accept;
  logic [15:0] etype_r;
  logic [7:0]  vihl_r, proto_r;
  logic [31:0] src_r, dst_r;
  logic [15:0] sport_r, dport_r;
  logic [6:0]  toff_cur, toff_hdr;
  logic [15:0] port_pos;
  logic        is_tcp, is_udp;
  logic [7:0]  need;
  logic [2:0]  status;
  logic [flk_pkg::Q_LVL_W:0] room_use;

  assign room_use = {1'b0, q_level} + {{flk_pkg::Q_LVL_W{1'b0}}, pend_r};
  // a pending result must always find a free queue slot next cycle
  assign in_stall = room_use >= {1'b0, flk_pkg::Q_FULL_LVL};
  assign accept   = in_valid && !in_stall;

  assign count_nxt = (count_r == flk_pkg::COUNT_MAX) ? count_r : count_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= accept && in_data.last_byte;
      if (accept) begin
        count_r <= in_data.last_byte ? '0 : count_nxt;
      end
    end
  end

  // transport offset; IHL may arrive on this very byte
  assign toff_hdr = flk_pkg::ETH_HDR_LEN + {1'b0, vihl_r[3:0], 2'b00};
  assign toff_cur = (count_r == flk_pkg::OFF_VER_IHL) ?
                    flk_pkg::ETH_HDR_LEN + {1'b0, in_data.packet_byte[3:0], 2'b00} : toff_hdr;
  assign port_pos = count_r - {9'd0, toff_cur};

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_data.last_byte) begin
        len_r <= count_nxt;
      end
      case (count_r)
        flk_pkg::OFF_ETYPE_HI: etype_r[15:8] <= in_data.packet_byte;
        flk_pkg::OFF_ETYPE_LO: etype_r[7:0]  <= in_data.packet_byte;
        flk_pkg::OFF_VER_IHL:  vihl_r        <= in_data.packet_byte;
        flk_pkg::OFF_PROTO:    proto_r       <= in_data.packet_byte;
        flk_pkg::OFF_SRC_0:    src_r[31:24]  <= in_data.packet_byte;
        flk_pkg::OFF_SRC_1:    src_r[23:16]  <= in_data.packet_byte;
        flk_pkg::OFF_SRC_2:    src_r[15:8]   <= in_data.packet_byte;
        flk_pkg::OFF_SRC_3:    src_r[7:0]    <= in_data.packet_byte;
        flk_pkg::OFF_DST_0:    dst_r[31:24]  <= in_data.packet_byte;
        flk_pkg::OFF_DST_1:    dst_r[23:16]  <= in_data.packet_byte;
        flk_pkg::OFF_DST_2:    dst_r[15:8]   <= in_data.packet_byte;
        flk_pkg::OFF_DST_3:    dst_r[7:0]    <= in_data.packet_byte;
        default: ;
      endcase
      if (port_pos < 16'd4) begin
        case (port_pos[1:0])
          2'd0:    sport_r[15:8] <= in_data.packet_byte;
          2'd1:    sport_r[7:0]  <= in_data.packet_byte;
          2'd2:    dport_r[15:8] <= in_data.packet_byte;
          default: dport_r[7:0]  <= in_data.packet_byte;
        endcase
      end
    end
  end

  // classification, in the cycle after the last byte is taken
  assign is_tcp = (proto_r == flk_pkg::PROTO_TCP);
  assign is_udp = (proto_r == flk_pkg::PROTO_UDP);
  assign need   = {1'b0, toff_hdr} + (is_tcp ? flk_pkg::TCP_HDR_LEN : flk_pkg::UDP_HDR_LEN);

  always_comb begin
    if (len_r < flk_pkg::MIN_FRAME_LEN) begin
      status = flk_pkg::ST_SHORT;
    end else if (etype_r != flk_pkg::ETHERTYPE_IP4) begin
      status = flk_pkg::ST_NOT_IPV4;
    end else if (vihl_r[7:4] != flk_pkg::IP_VERSION) begin
      status = flk_pkg::ST_BAD_VER;
    end else if ((is_tcp || is_udp) && (len_r < {8'd0, need})) begin
      status = flk_pkg::ST_TRUNCATED;
    end else begin
      status = flk_pkg::ST_OK;
    end
  end

  assign q_push                      = pend_r;
  assign q_wdata.status              = status;
  assign q_wdata.source_address      = src_r;
  assign q_wdata.destination_address = dst_r;
  assign q_wdata.source_port         = (is_tcp || is_udp) ? sport_r : '0;
  assign q_wdata.destination_port    = (is_tcp || is_udp) ? dport_r : '0;
  assign q_wdata.protocol_number     = proto_r;

endmodule

/* sv/flk_queue.sv */
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
module flk_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  flk_pkg::out_item_t           wdata,
  input  logic                         pop,
  output flk_pkg::out_item_t           rdata,
  output logic                         empty,
  output logic [flk_pkg::Q_LVL_W-1:0]  level
);

  flk_pkg::out_item_t               mem_r [flk_pkg::Q_DEPTH];
  logic [flk_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [flk_pkg::Q_LVL_W-1:0]      level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + flk_pkg::Q_PTR_ONE;
      if (pop)  rd_ptr_r <= rd_ptr_r + flk_pkg::Q_PTR_ONE;
      case ({push, pop})
        2'b10:   level_r <= level_r + flk_pkg::Q_LVL_ONE;
        2'b01:   level_r <= level_r - flk_pkg::Q_LVL_ONE;
        default: level_r <= level_r;
      endcase
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

endmodule

/* sv/flk_back.sv */
// Output stage: clears the key on error status and holds the result register.
`timescale 1ns / 1ps
module flk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  flk_pkg::out_item_t  q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output flk_pkg::out_item_t  out_data
);

  logic               out_valid_r;
  flk_pkg::out_item_t out_data_r, out_data_nxt;
  logic               load;

  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    out_data_nxt = q_rdata;
    if (q_rdata.status != flk_pkg::ST_OK) begin
      out_data_nxt                     = '0;
      out_data_nxt.status              = q_rdata.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/ipv4_flow_key_extractor.sv */
// Top level of the IPv4 flow key extractor.
//
//   channel | direction | transaction
//   in_*    | input     | one frame byte plus last-byte flag
//   out_*   | output    | status and flow key, one per frame
//
// One byte is taken every cycle while in_stall is low; frames may follow
// each other with no gap. A result reaches out_valid through the field
// capture registers, then the result queue and the output register.
// Reset clears the byte counter, the queue and out_valid.
// in_stall rises when the result queue could not hold another result;
// out_stall holds the output register and lets the queue fill.
`timescale 1ns / 1ps
module ipv4_flow_key_extractor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  flk_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output flk_pkg::out_item_t  out_data
);

  logic                         q_push, q_pop, q_empty;
  logic [flk_pkg::Q_LVL_W-1:0]  q_level;
  flk_pkg::out_item_t           q_wdata, q_rdata;

  flk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  flk_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  flk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // the stall rule must leave room for every pending result
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level != flk_pkg::Q_FULL_LVL))
    else $error("result queue overflow");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_byte) |=> q_push)
    else $error("frame end produced no result");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty result queue");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != flk_pkg::ST_OK) |->
      (out_data.source_address == '0 && out_data.destination_address == '0 &&
       out_data.source_port == '0 && out_data.destination_port == '0 &&
       out_data.protocol_number == '0))
    else $error("flow key not cleared on error status");

endmodule

/* tb/sv/tb_ipv4_flow_key_extractor.sv */
// Self-checking testbench for the IPv4 flow key extractor: table-driven and random frames.
`timescale 1ns / 1ps
module tb_ipv4_flow_key_extractor;

  localparam int HDR_BYTES = 78;
  localparam int RAND_BYTES = 910;
  localparam int RAND_MIN_FRAMES = 16;

  // one directed frame: length, header bytes forced in, background fill,
  // and a typed-in status when the result is obvious (all other fields zero)
  typedef struct packed {
    logic [16:0] len;
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [7:0]  fill;
    logic        typed;
    logic [2:0]  status;
  } frame_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  flk_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  flk_pkg::out_item_t out_data;

  // predictor state
  logic [7:0]  hdr_mem [HDR_BYTES];
  int unsigned frame_len;

  flk_pkg::out_item_t pending_keys [$];
  logic [7:0]         frame_bytes [$];
  int                 mismatches = 0;
  int                 burst_left = 0;
  bit                 gaps_on = 1'b1;
  bit                 long_hold_req = 1'b0;
  flk_pkg::out_item_t mon_want;

  frame_row_t dir_rows [19] = '{
    '{17'd1,  16'h0800, 8'h45, 8'h06, 8'h00, 1'b1, flk_pkg::ST_SHORT},
    '{17'd33, 16'h0800, 8'h45, 8'h06, 8'hFF, 1'b1, flk_pkg::ST_SHORT},
    '{17'd34, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, flk_pkg::ST_NOT_IPV4},
    '{17'd34, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, flk_pkg::ST_NOT_IPV4},
    '{17'd34, 16'h0008, 8'h45, 8'h11, 8'h10, 1'b1, flk_pkg::ST_NOT_IPV4},
    '{17'd34, 16'h0801, 8'h45, 8'h11, 8'h20, 1'b1, flk_pkg::ST_NOT_IPV4},
    '{17'd34, 16'h0800, 8'h55, 8'h06, 8'h30, 1'b1, flk_pkg::ST_BAD_VER},
    '{17'd34, 16'h0800, 8'hF5, 8'h11, 8'h40, 1'b1, flk_pkg::ST_BAD_VER},
    '{17'd34, 16'h0800, 8'h45, 8'h06, 8'h50, 1'b1, flk_pkg::ST_TRUNCATED},
    '{17'd53, 16'h0800, 8'h45, 8'h06, 8'h60, 1'b1, flk_pkg::ST_TRUNCATED},
    '{17'd41, 16'h0800, 8'h45, 8'h11, 8'h70, 1'b1, flk_pkg::ST_TRUNCATED},
    '{17'd42, 16'h0800, 8'h45, 8'h11, 8'hA5, 1'b0, flk_pkg::ST_OK},
    '{17'd54, 16'h0800, 8'h45, 8'h06, 8'h5A, 1'b0, flk_pkg::ST_OK},
    '{17'd34, 16'h0800, 8'h45, 8'h01, 8'hFF, 1'b0, flk_pkg::ST_OK},
    // IHL of zero: transport header overlaps the IP header
    '{17'd34, 16'h0800, 8'h40, 8'h06, 8'h00, 1'b0, flk_pkg::ST_OK},
    // IHL 15: ports sit in the last bytes of the store
    '{17'd93, 16'h0800, 8'h4F, 8'h06, 8'h80, 1'b1, flk_pkg::ST_TRUNCATED},
    '{17'd94, 16'h0800, 8'h4F, 8'h06, 8'h90, 1'b0, flk_pkg::ST_OK},
    '{17'd81, 16'h0800, 8'h4F, 8'h11, 8'hC0, 1'b1, flk_pkg::ST_TRUNCATED},
    '{17'd82, 16'h0800, 8'h4F, 8'h11, 8'hD0, 1'b0, flk_pkg::ST_OK}
  };

  ipv4_flow_key_extractor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] hdr_at(int unsigned pos);
    return (pos < HDR_BYTES) ? hdr_mem[pos] : 8'h00;
  endfunction

  // advance the frame state by one byte; returns 1 when a flow key is produced
  function automatic bit flow_key_step(input flk_pkg::in_item_t it,
                                       output flk_pkg::out_item_t key);
    int unsigned len;
    int unsigned toff;
    int unsigned need;
    logic [7:0]  vi;
    logic [7:0]  proto;
    key = '0;
    if (frame_len < HDR_BYTES) hdr_mem[frame_len] = it.packet_byte;
    if (frame_len < flk_pkg::COUNT_MAX) frame_len++;
    if (!it.last_byte) return 1'b0;
    len = frame_len;
    frame_len = 0;
    vi = hdr_at(flk_pkg::OFF_VER_IHL);
    if (len < flk_pkg::MIN_FRAME_LEN) begin
      key.status = flk_pkg::ST_SHORT;
    end else if ({hdr_at(flk_pkg::OFF_ETYPE_HI), hdr_at(flk_pkg::OFF_ETYPE_LO)} !=
                 flk_pkg::ETHERTYPE_IP4) begin
      key.status = flk_pkg::ST_NOT_IPV4;
    end else if (vi[7:4] != flk_pkg::IP_VERSION) begin
      key.status = flk_pkg::ST_BAD_VER;
    end else begin
      toff = flk_pkg::ETH_HDR_LEN + 4 * vi[3:0];
      proto = hdr_at(flk_pkg::OFF_PROTO);
      need = 0;
      if (proto == flk_pkg::PROTO_TCP) need = toff + flk_pkg::TCP_HDR_LEN;
      if (proto == flk_pkg::PROTO_UDP) need = toff + flk_pkg::UDP_HDR_LEN;
      if (len < need) begin
        key.status = flk_pkg::ST_TRUNCATED;
      end else begin
        key.status = flk_pkg::ST_OK;
        key.protocol_number = proto;
        key.source_address = {hdr_at(flk_pkg::OFF_SRC_0), hdr_at(flk_pkg::OFF_SRC_1),
                              hdr_at(flk_pkg::OFF_SRC_2), hdr_at(flk_pkg::OFF_SRC_3)};
        key.destination_address = {hdr_at(flk_pkg::OFF_DST_0), hdr_at(flk_pkg::OFF_DST_1),
                                   hdr_at(flk_pkg::OFF_DST_2), hdr_at(flk_pkg::OFF_DST_3)};
        if (need != 0) begin
          key.source_port = {hdr_at(toff), hdr_at(toff + 1)};
          key.destination_port = {hdr_at(toff + 2), hdr_at(toff + 3)};
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result side: compare each accepted transaction with the oldest pending key
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_keys.size() == 0) begin
        flag_mismatch("flow key with no frame pending");
      end else begin
        mon_want = pending_keys.pop_front();
        check_field("status", 32'(out_data.status), 32'(mon_want.status));
        check_field("source_address", out_data.source_address, mon_want.source_address);
        check_field("destination_address", out_data.destination_address,
                    mon_want.destination_address);
        check_field("source_port", 32'(out_data.source_port),
                    32'(mon_want.source_port));
        check_field("destination_port", 32'(out_data.destination_port),
                    32'(mon_want.destination_port));
        check_field("protocol_number", 32'(out_data.protocol_number),
                    32'(mon_want.protocol_number));
      end
    end
  end

  // receiver: stall patterns that change every so often, plus a long hold on request
  initial begin : rx_side
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 5 < 2);
        endcase
      end
    end
  end

  // offer one byte, wait for it to be taken, then predict
  task automatic send_byte(input flk_pkg::in_item_t it, input bit use_typed,
                           input flk_pkg::out_item_t typed_key);
    flk_pkg::out_item_t key;
    int                 gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                                 : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (flow_key_step(it, key)) pending_keys.push_back(use_typed ? typed_key : key);
    burst_left--;
  endtask

  task automatic send_frame(input bit use_typed, input logic [2:0] typed_status);
    flk_pkg::in_item_t  it;
    flk_pkg::out_item_t typed_key;
    int                 n;
    typed_key = '0;
    typed_key.status = typed_status;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      it.packet_byte = frame_bytes[i];
      it.last_byte = (i == n - 1);
      send_byte(it, use_typed, typed_key);
    end
  endtask

  task automatic put_byte(input int idx, input logic [7:0] val);
    if (idx < frame_bytes.size()) frame_bytes[idx] = val;
  endtask

  task automatic put_header(input logic [15:0] etype, input logic [7:0] ver_ihl,
                            input logic [7:0] proto);
    put_byte(flk_pkg::OFF_ETYPE_HI, etype[15:8]);
    put_byte(flk_pkg::OFF_ETYPE_LO, etype[7:0]);
    put_byte(flk_pkg::OFF_VER_IHL, ver_ihl);
    put_byte(flk_pkg::OFF_PROTO, proto);
  endtask

  // mostly well-formed IPv4 frames around the truncation boundary, plus noise
  task automatic build_random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned ihl;
    int unsigned need;
    logic [7:0]  proto;
    kind = $urandom_range(0, 9);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    case ($urandom_range(0, 5))
      0, 1: proto = flk_pkg::PROTO_TCP;
      2, 3: proto = flk_pkg::PROTO_UDP;
      4: proto = 8'd1;
      default: proto = 8'($urandom_range(0, 255));
    endcase
    need = flk_pkg::ETH_HDR_LEN + 4 * ihl;
    if (proto == flk_pkg::PROTO_TCP) need += flk_pkg::TCP_HDR_LEN;
    if (proto == flk_pkg::PROTO_UDP) need += flk_pkg::UDP_HDR_LEN;
    if (need < flk_pkg::MIN_FRAME_LEN) need = flk_pkg::MIN_FRAME_LEN;
    if (kind <= 6) len = need - 3 + $urandom_range(0, 15);
    else if (kind == 7) len = $urandom_range(1, 33);
    else len = $urandom_range(34, 110);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind <= 7) begin
      put_header(flk_pkg::ETHERTYPE_IP4, {flk_pkg::IP_VERSION, ihl[3:0]}, proto);
    end else if (kind == 9) begin
      put_header(flk_pkg::ETHERTYPE_IP4, 8'($urandom_range(0, 255)), proto);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stim
    int rand_bytes;
    int rand_frames;
    bit mid_pause_done;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
    frame_len = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      frame_bytes.delete();
      for (int i = 0; i < dir_rows[r].len; i++)
        frame_bytes.push_back(dir_rows[r].fill + i[7:0]);
      put_header(dir_rows[r].etype, dir_rows[r].ver_ihl, dir_rows[r].proto);
      send_frame(dir_rows[r].typed, dir_rows[r].status);
    end

    // back-pressure: receiver holds while one-byte frames keep coming
    long_hold_req = 1'b1;
    gaps_on = 1'b0;
    for (int i = 0; i < 60; i++) begin
      frame_bytes.delete();
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      send_frame(1'b1, flk_pkg::ST_SHORT);
    end
    gaps_on = 1'b1;
    wait_drained();

    rand_bytes = 0;
    rand_frames = 0;
    mid_pause_done = 1'b0;
    while (rand_bytes < RAND_BYTES || rand_frames < RAND_MIN_FRAMES) begin
      build_random_frame();
      rand_bytes += frame_bytes.size();
      rand_frames++;
      send_frame(1'b0, flk_pkg::ST_OK);
      if (!mid_pause_done && rand_bytes >= RAND_BYTES / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/flk_pkg.sv
sv/flk_front.sv
sv/flk_queue.sv
sv/flk_back.sv
sv/ipv4_flow_key_extractor.sv
tb/sv/tb_ipv4_flow_key_extractor.sv
